// ----- hdl/mcfe_pkg.sv -----
// types and constants shared by the motor command frame encoder
`timescale 1ns / 1ps
`default_nettype none

package mcfe_pkg;

    localparam int BYTE_W     = 8;
    localparam int REP_W      = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int FRAME_LEN  = 6;
    localparam int POS_W      = 3;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = 2;

    localparam logic [BYTE_W-1:0] FRAME_OPEN  = 8'hFC;
    localparam logic [BYTE_W-1:0] FRAME_CLOSE = 8'hFD;

    // command characters
    localparam logic [BYTE_W-1:0] CMD_STOP     = 8'h4F; // O
    localparam logic [BYTE_W-1:0] CMD_FORWARD  = 8'h57; // W
    localparam logic [BYTE_W-1:0] CMD_LEFT     = 8'h41; // A
    localparam logic [BYTE_W-1:0] CMD_RIGHT    = 8'h44; // D
    localparam logic [BYTE_W-1:0] CMD_BACKWARD = 8'h53; // S
    localparam logic [BYTE_W-1:0] CMD_SLOW     = 8'h49; // I
    localparam logic [BYTE_W-1:0] CMD_FAST     = 8'h4B; // K

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_LIMIT      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NORMAL_REPEAT    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STOP_REPEAT      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FORWARD_SPEED    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BACKWARD_SPEED   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SLOW_SPEED       = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_FAST_SPEED       = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_TURN_INNER_SPEED = 3'd7;

    // frame byte positions
    localparam logic [POS_W-1:0] POS_OPEN  = 3'd0;
    localparam logic [POS_W-1:0] POS_LDIR  = 3'd1;
    localparam logic [POS_W-1:0] POS_LSPD  = 3'd2;
    localparam logic [POS_W-1:0] POS_RDIR  = 3'd3;
    localparam logic [POS_W-1:0] POS_RSPD  = 3'd4;
    localparam logic [POS_W-1:0] POS_CLOSE = 3'd5;

    typedef struct packed {
        logic              ldir;
        logic [BYTE_W-1:0] lspd;
        logic              rdir;
        logic [BYTE_W-1:0] rspd;
        logic [REP_W-1:0]  reps;
    } frame_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/mcfe_front.sv -----
// command decode, speed split and saturation, configuration registers
`timescale 1ns / 1ps
`default_nettype none

module mcfe_front import mcfe_pkg::*; #(
    parameter int MAX_REPEAT = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [BYTE_W-1:0]     cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [BYTE_W-1:0]     s_tdata,
    input  wire logic                  q_full,
    output logic                       q_push,
    output frame_cmd_t                 q_entry
);

    localparam logic [REP_W-1:0] MaxRep = REP_W'(MAX_REPEAT);

    logic [BYTE_W-1:0] speed_limit_reg;
    logic [REP_W-1:0]  normal_repeat_reg;
    logic [REP_W-1:0]  stop_repeat_reg;
    logic [BYTE_W-1:0] forward_speed_reg;
    logic [BYTE_W-1:0] backward_speed_reg;
    logic [BYTE_W-1:0] slow_speed_reg;
    logic [BYTE_W-1:0] fast_speed_reg;
    logic [BYTE_W-1:0] turn_inner_speed_reg;

    logic              known;
    logic [BYTE_W-1:0] lmag;
    logic [BYTE_W-1:0] rmag;
    logic              lrev;
    logic              rrev;
    logic [REP_W-1:0]  reps;
    logic [REP_W-1:0]  reps_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_limit_reg      <= 8'd150;
            normal_repeat_reg    <= 4'd3;
            stop_repeat_reg      <= 4'd8;
            forward_speed_reg    <= 8'd150;
            backward_speed_reg   <= 8'd150;
            slow_speed_reg       <= 8'd100;
            fast_speed_reg       <= 8'd150;
            turn_inner_speed_reg <= 8'd50;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_SPEED_LIMIT:      speed_limit_reg      <= cfg_wdata;
                REG_NORMAL_REPEAT:    normal_repeat_reg    <= cfg_wdata[REP_W-1:0];
                REG_STOP_REPEAT:      stop_repeat_reg      <= cfg_wdata[REP_W-1:0];
                REG_FORWARD_SPEED:    forward_speed_reg    <= cfg_wdata;
                REG_BACKWARD_SPEED:   backward_speed_reg   <= cfg_wdata;
                REG_SLOW_SPEED:       slow_speed_reg       <= cfg_wdata;
                REG_FAST_SPEED:       fast_speed_reg       <= cfg_wdata;
                REG_TURN_INNER_SPEED: turn_inner_speed_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        known = 1'b1;
        lmag  = '0;
        rmag  = '0;
        lrev  = 1'b0;
        rrev  = 1'b0;
        reps  = normal_repeat_reg;
        case (s_tdata)
            CMD_STOP: begin
                reps = stop_repeat_reg;
            end
            CMD_FORWARD: begin
                lmag = forward_speed_reg;
                rmag = forward_speed_reg;
            end
            CMD_LEFT: begin
                lmag = turn_inner_speed_reg;
                lrev = 1'b1;
                rmag = fast_speed_reg;
            end
            CMD_RIGHT: begin
                lmag = fast_speed_reg;
                rmag = turn_inner_speed_reg;
                rrev = 1'b1;
            end
            CMD_BACKWARD: begin
                lmag = backward_speed_reg;
                rmag = backward_speed_reg;
                lrev = 1'b1;
                rrev = 1'b1;
            end
            CMD_SLOW: begin
                lmag = slow_speed_reg;
                rmag = slow_speed_reg;
            end
            CMD_FAST: begin
                lmag = fast_speed_reg;
                rmag = fast_speed_reg;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    assign reps_sat = (reps > MaxRep) ? MaxRep : reps;

    // a reverse wheel at zero speed goes out with direction 0
    assign q_entry.ldir = lrev && (lmag != '0);
    assign q_entry.lspd = (lmag > speed_limit_reg) ? speed_limit_reg : lmag;
    assign q_entry.rdir = rrev && (rmag != '0);
    assign q_entry.rspd = (rmag > speed_limit_reg) ? speed_limit_reg : rmag;
    assign q_entry.reps = reps_sat;

    assign s_tready = !q_full;
    // ignored bytes and zero repeats are taken and dropped
    assign q_push   = s_tvalid && !q_full && known && (reps_sat != '0);

endmodule

`default_nettype wire

// ----- hdl/mcfe_queue.sv -----
// two-entry command queue between decode and frame output
`timescale 1ns / 1ps
`default_nettype none

module mcfe_queue import mcfe_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire frame_cmd_t  push_entry,
    output logic             full,
    input  wire logic        pop,
    output frame_cmd_t       head,
    output logic             empty
);

    frame_cmd_t             mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]     wr_ptr_reg;
    logic [Q_PTR_W-1:0]     rd_ptr_reg;
    logic [Q_CNT_W-1:0]     count_reg;
    logic [Q_CNT_W-1:0]     count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full    = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_push_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue push lost");

    a_pop_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue pop lost");

endmodule

`default_nettype wire

// ----- hdl/mcfe_back.sv -----
// frame sequencer and registered output stage
`timescale 1ns / 1ps
`default_nettype none

module mcfe_back import mcfe_pkg::*; (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire frame_cmd_t    q_head,
    input  wire logic          q_empty,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [BYTE_W-1:0]  m_tdata,
    output logic               m_tlast,
    output logic               m_tuser
);

    frame_cmd_t         cur_reg;
    logic               active_reg;
    logic               active_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [REP_W-1:0]   left_reg;
    logic [REP_W-1:0]   left_next;
    logic               m_tvalid_reg;
    logic               m_tvalid_next;
    logic [BYTE_W-1:0]  m_tdata_reg;
    logic [BYTE_W-1:0]  byte_sel;
    logic               m_tlast_reg;
    logic               m_tuser_reg;
    logic               out_free;
    logic               emit;
    logic               at_close;
    logic               run_end;

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = active_reg && out_free;
    assign q_pop    = !active_reg && !q_empty;
    assign at_close = (pos_reg == POS_CLOSE);
    assign run_end  = at_close && (left_reg == REP_W'(1));

    always_comb begin
        case (pos_reg)
            POS_OPEN:  byte_sel = FRAME_OPEN;
            POS_LDIR:  byte_sel = {{(BYTE_W-1){1'b0}}, cur_reg.ldir};
            POS_LSPD:  byte_sel = cur_reg.lspd;
            POS_RDIR:  byte_sel = {{(BYTE_W-1){1'b0}}, cur_reg.rdir};
            POS_RSPD:  byte_sel = cur_reg.rspd;
            POS_CLOSE: byte_sel = FRAME_CLOSE;
            default:   byte_sel = FRAME_CLOSE;
        endcase
    end

    always_comb begin
        active_next   = active_reg;
        pos_next      = pos_reg;
        left_next     = left_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (q_pop) begin
            active_next = 1'b1;
            pos_next    = POS_OPEN;
            left_next   = q_head.reps;
        end else if (emit) begin
            m_tvalid_next = 1'b1;
            if (at_close) begin
                pos_next  = POS_OPEN;
                left_next = left_reg - 1'b1;
                if (run_end) begin
                    active_next = 1'b0;
                end
            end else begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_head;
        end
        if (emit) begin
            m_tdata_reg <= byte_sel;
            m_tlast_reg <= at_close;
            m_tuser_reg <= run_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            pos_reg      <= POS_OPEN;
            left_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            active_reg   <= active_next;
            pos_reg      <= pos_next;
            left_reg     <= left_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    a_run_end_closes_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg) |-> m_tlast_reg)
        else $error("run end not on a frame close");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (pos_reg <= POS_CLOSE))
        else $error("frame position out of range");

    a_frames_left: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (left_reg != '0))
        else $error("active with no frames left");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |-> !emit)
        else $error("output overwritten while stalled");

endmodule

`default_nettype wire

// ----- hdl/motor_command_frame_encoder.sv -----
// Takes one command character per item and sends the six-byte motor frame
// (FC, left dir, left speed, right dir, right speed, FD) repeat times, one byte
// per item on the output. O, W, A, D, S, I and K are commands; every other byte
// is taken and produces nothing, as does a repeat count of zero. Repeat counts
// above MAX_REPEAT are held at MAX_REPEAT. A command produces 6 * repeat output
// items at one per cycle while the output is not stalled, after the frame
// sequencer loads it from the two-entry command queue. The input keeps
// accepting while the queue has room; the output byte stream sets the rate.
// tlast marks the closing byte of each frame, tuser the last byte of the run.
// Configuration registers are written through cfg_we / cfg_addr / cfg_wdata;
// the user is to write them while the block is idle; the block itself does not
// enforce this.
`timescale 1ns / 1ps
`default_nettype none

module motor_command_frame_encoder import mcfe_pkg::*; #(
    parameter int MAX_REPEAT = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [BYTE_W-1:0]     cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [BYTE_W-1:0]     s_tdata,   // [7:0] command_byte
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [BYTE_W-1:0]          m_tdata,   // [7:0] frame_byte
    output logic                       m_tlast,   // frame_last
    output logic                       m_tuser    // [0] run_last
);

    frame_cmd_t push_entry;
    frame_cmd_t head;
    logic       push;
    logic       full;
    logic       pop;
    logic       empty;

    mcfe_front #(
        .MAX_REPEAT(MAX_REPEAT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (full),
        .q_push    (push),
        .q_entry   (push_entry)
    );

    mcfe_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .empty      (empty)
    );

    mcfe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_head   (head),
        .q_empty  (empty),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ----- tb/motor_command_frame_encoder_test.sv -----
// self-checking testbench for the motor command frame encoder with a frame predictor
`timescale 1ns / 1ps

module motor_command_frame_encoder_test import mcfe_pkg::*; ();

    localparam int MAX_REPEAT     = 8;
    localparam int DRAIN_CYCLES   = 60;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 38;
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    typedef struct {
        logic [BYTE_W-1:0] frame_byte;
        logic              frame_last;
        logic              run_last;
    } frame_item_t;

    class frame_predictor;
        logic [BYTE_W-1:0] reg_value [8];
        frame_item_t       expected_bytes [$];
        int                mismatches;

        function new();
            reg_value[REG_SPEED_LIMIT]      = 8'd150;
            reg_value[REG_NORMAL_REPEAT]    = 8'd3;
            reg_value[REG_STOP_REPEAT]      = 8'd8;
            reg_value[REG_FORWARD_SPEED]    = 8'd150;
            reg_value[REG_BACKWARD_SPEED]   = 8'd150;
            reg_value[REG_SLOW_SPEED]       = 8'd100;
            reg_value[REG_FAST_SPEED]       = 8'd150;
            reg_value[REG_TURN_INNER_SPEED] = 8'd50;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [BYTE_W-1:0] value);
            if (idx == REG_NORMAL_REPEAT || idx == REG_STOP_REPEAT) begin
                reg_value[idx] = value & 8'h0F;
            end else begin
                reg_value[idx] = value;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function logic [BYTE_W-1:0] clip(logic [BYTE_W-1:0] mag);
            return (mag > reg_value[REG_SPEED_LIMIT]) ? reg_value[REG_SPEED_LIMIT] : mag;
        endfunction

        function void note_command(logic [BYTE_W-1:0] cmd);
            logic [BYTE_W-1:0] lmag;
            logic [BYTE_W-1:0] rmag;
            logic              lrev;
            logic              rrev;
            logic [BYTE_W-1:0] reps;
            logic [BYTE_W-1:0] frame [FRAME_LEN];
            frame_item_t       item;
            int                total;
            lmag = '0;
            rmag = '0;
            lrev = 1'b0;
            rrev = 1'b0;
            reps = reg_value[REG_NORMAL_REPEAT];
            case (cmd)
                CMD_STOP: begin
                    reps = reg_value[REG_STOP_REPEAT];
                end
                CMD_FORWARD: begin
                    lmag = reg_value[REG_FORWARD_SPEED];
                    rmag = reg_value[REG_FORWARD_SPEED];
                end
                CMD_LEFT: begin
                    lmag = reg_value[REG_TURN_INNER_SPEED];
                    lrev = 1'b1;
                    rmag = reg_value[REG_FAST_SPEED];
                end
                CMD_RIGHT: begin
                    lmag = reg_value[REG_FAST_SPEED];
                    rmag = reg_value[REG_TURN_INNER_SPEED];
                    rrev = 1'b1;
                end
                CMD_BACKWARD: begin
                    lmag = reg_value[REG_BACKWARD_SPEED];
                    rmag = reg_value[REG_BACKWARD_SPEED];
                    lrev = 1'b1;
                    rrev = 1'b1;
                end
                CMD_SLOW: begin
                    lmag = reg_value[REG_SLOW_SPEED];
                    rmag = reg_value[REG_SLOW_SPEED];
                end
                CMD_FAST: begin
                    lmag = reg_value[REG_FAST_SPEED];
                    rmag = reg_value[REG_FAST_SPEED];
                end
                default: begin
                    return;
                end
            endcase
            if (reps > MAX_REPEAT) reps = BYTE_W'(MAX_REPEAT);
            // a reverse wheel at zero magnitude goes out as forward
            frame[POS_OPEN]  = FRAME_OPEN;
            frame[POS_LDIR]  = {7'd0, lrev && (lmag != 0)};
            frame[POS_LSPD]  = clip(lmag);
            frame[POS_RDIR]  = {7'd0, rrev && (rmag != 0)};
            frame[POS_RSPD]  = clip(rmag);
            frame[POS_CLOSE] = FRAME_CLOSE;
            total = reps * FRAME_LEN;
            for (int n = 0; n < total; n++) begin
                item.frame_byte = frame[n % FRAME_LEN];
                item.frame_last = ((n % FRAME_LEN) == FRAME_LEN - 1);
                item.run_last   = (n == total - 1);
                expected_bytes.push_back(item);
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_byte(logic [BYTE_W-1:0] data, logic last, logic user);
            frame_item_t item;
            if (expected_bytes.size() == 0) begin
                report($sformatf("unexpected item %02h last %0b run_last %0b", data, last, user));
            end else begin
                item = expected_bytes.pop_front();
                if (data !== item.frame_byte)
                    report($sformatf("frame_byte %02h, want %02h", data, item.frame_byte));
                if (last !== item.frame_last)
                    report($sformatf("frame_last %0b, want %0b", last, item.frame_last));
                if (user !== item.run_last)
                    report($sformatf("run_last %0b, want %0b", user, item.run_last));
            end
        endtask
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [BYTE_W-1:0]     cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [BYTE_W-1:0]     m_tdata;   // [7:0] frame_byte
    logic                  m_tlast;   // frame_last
    logic                  m_tuser;   // [0] run_last

    frame_predictor sb = new();
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  long_hold_req = 1'b0;
    int  stall_left = 0;
    int  idle_cycles = 0;

    motor_command_frame_encoder #(
        .MAX_REPEAT(MAX_REPEAT)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int pick_gap(int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_byte(m_tdata, m_tlast, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
                $display("[motor_command_frame_encoder] ERROR");
                $finish;
            end
        end
    end

    // receiver back-pressure
    initial begin
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0) m_tready <= 1'b1;
            end else begin
                stall_left = pick_gap(recv_idle_pct);
                m_tready <= (stall_left == 0);
            end
        end
    end

    // entered and left at a falling edge
    task automatic issue(input logic [BYTE_W-1:0] cmd);
        int gap;
        s_tdata  <= cmd;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_command(cmd);
        @(negedge aclk);
        gap = pick_gap(send_idle_pct);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic config_write(input logic [CFG_ADDR_W-1:0] idx, input logic [BYTE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        sb.set_reg(idx, value);
        @(negedge aclk);
    endtask

    function automatic logic [BYTE_W-1:0] random_reg_value(int idx);
        int r;
        r = $urandom_range(0, 9);
        if (idx == REG_NORMAL_REPEAT || idx == REG_STOP_REPEAT) begin
            case (r)
                0: return 8'd0;
                1: return 8'd8;
                2: return 8'd15;
                3: return BYTE_W'($urandom_range(0, 255));
                default: return BYTE_W'($urandom_range(1, 8));
            endcase
        end
        case (r)
            0: return 8'd0;
            1: return 8'd255;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] random_command();
        if ($urandom_range(0, 99) >= 80) return BYTE_W'($urandom_range(0, 255));
        case ($urandom_range(0, 6))
            0: return CMD_STOP;
            1: return CMD_FORWARD;
            2: return CMD_LEFT;
            3: return CMD_RIGHT;
            4: return CMD_BACKWARD;
            5: return CMD_SLOW;
            default: return CMD_FAST;
        endcase
    endfunction

    task automatic random_phase(input int send_pct, input int recv_pct, input bit hold);
        for (int i = 0; i < 8; i++) config_write(CFG_ADDR_W'(i), random_reg_value(i));
        cfg_we <= 1'b0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        if (hold) long_hold_req = 1'b1;
        for (int n = 0; n < PHASE_ITEMS; n++) issue(random_command());
        settle();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings, every command and some ignored bytes
        issue(CMD_STOP);
        issue(CMD_FORWARD);
        issue(CMD_LEFT);
        issue(CMD_RIGHT);
        issue(CMD_BACKWARD);
        issue(CMD_SLOW);
        issue(CMD_FAST);
        issue(CHAR_CR);
        issue(CHAR_LF);
        issue(8'h00);
        issue(8'hFF);
        settle();

        // top speeds, repeat over bound, no stop frames, zero reverse speeds
        config_write(REG_SPEED_LIMIT, 8'd255);
        config_write(REG_NORMAL_REPEAT, 8'd15);
        config_write(REG_STOP_REPEAT, 8'd0);
        config_write(REG_FORWARD_SPEED, 8'd255);
        config_write(REG_BACKWARD_SPEED, 8'd0);
        config_write(REG_SLOW_SPEED, 8'd0);
        config_write(REG_FAST_SPEED, 8'd255);
        config_write(REG_TURN_INNER_SPEED, 8'd0);
        cfg_we <= 1'b0;
        issue(CMD_STOP);
        issue(CMD_FORWARD);
        issue(CMD_BACKWARD);
        issue(CMD_LEFT);
        issue(CMD_RIGHT);
        issue(CMD_SLOW);
        issue(CMD_FAST);
        settle();

        // zero limit, no motion frames, single stop frame
        config_write(REG_SPEED_LIMIT, 8'd0);
        config_write(REG_NORMAL_REPEAT, 8'd0);
        config_write(REG_STOP_REPEAT, 8'd1);
        cfg_we <= 1'b0;
        issue(CMD_FORWARD);
        issue(CMD_STOP);
        issue(CMD_LEFT);
        settle();

        random_phase(0, 0, 1'b0);
        random_phase(30, 30, 1'b0);
        random_phase(50, 20, 1'b1);
        random_phase(20, 60, 1'b0);
        random_phase(60, 10, 1'b0);
        random_phase(25, 25, 1'b0);

        if (sb.pending() != 0) sb.report($sformatf("%0d items never arrived", sb.pending()));
        if (sb.mismatches == 0) begin
            $display("[motor_command_frame_encoder] OK");
        end else begin
            $display("[motor_command_frame_encoder] ERROR");
        end
        $finish;
    end

endmodule
